[rtl/sbl_pkg.sv]
// ----------------------------------------------------------------------------
// sbl_pkg
// shared constants and types of the stack blur line filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

    localparam int MAX_RADIUS_DEF = 31;

    // register indexes of the configuration port
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_MULT   = 2'd1;
    localparam logic [1:0] REG_SHIFT  = 2'd2;

    localparam logic [4:0] RADIUS_RST = 5'd1;
    localparam logic [9:0] MULT_RST   = 10'd512;
    localparam logic [4:0] SHIFT_RST  = 5'd11;

    // radius port is 5 bits, so the sums have fixed widths
    localparam int SUM_W  = 18;
    localparam int RUN_W  = 13;
    localparam int PROD_W = SUM_W + 10;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic        first;
        logic        xnn;
        logic        onn;
        logic        fwd;
        logic        last;
        logic [31:0] newval;
    } step_t;

endpackage

`default_nettype wire

[rtl/sbl_ram.sv]
// ----------------------------------------------------------------------------
// sbl_ram
// window ring: one write port, two registered read ports, read-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbl_ram #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [31:0]   rdata_a,
    output logic      [31:0]   rdata_b
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[rtl/sbl_acc.sv]
// ----------------------------------------------------------------------------
// sbl_acc
// running stack sums per channel, scale multiply and shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbl_acc (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s1_valid,
    input  wire sbl_pkg::step_t step,
    input  wire logic [31:0]   rd_x,
    input  wire logic [31:0]   rd_o,
    input  wire logic [31:0]   p0,
    input  wire logic [4:0]    r_eff,
    input  wire logic [9:0]    mult,
    input  wire logic [4:0]    shift,
    output logic               push,
    output logic [31:0]        push_pixel,
    output logic               push_last
);
    import sbl_pkg::*;

    logic [5:0]        r1;
    logic [10:0]       rsq_reg;
    logic [SUM_W-1:0]  s_reg [3];
    logic [SUM_W-1:0]  s_next [3];
    logic [RUN_W-1:0]  a_reg [3];
    logic [RUN_W-1:0]  a_next [3];
    logic [RUN_W-1:0]  b_reg [3];
    logic [RUN_W-1:0]  b_next [3];
    logic [7:0]        pq_reg [3];
    logic [7:0]        pq_next [3];
    logic [7:0]        pn [3];
    logic [7:0]        qx [3];
    logic [7:0]        qo [3];
    logic [PROD_W-1:0] prod_reg [3];
    logic [PROD_W-1:0] sh [3];
    logic              e2_reg;
    logic              last2_reg;
    logic [7:0]        alpha2_reg;
    logic              e3_reg;
    logic              last3_reg;
    logic [7:0]        alpha3_reg;

    assign r1 = {1'b0, r_eff} + 6'd1;

    always_ff @(posedge clk)
    begin
        rsq_reg <= 11'(r1 * r1);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pn[c] = step.newval[c*8 +: 8];
            qx[c] = step.fwd ? pn[c] : (step.xnn ? rd_x[c*8 +: 8] : p0[c*8 +: 8]);
            qo[c] = step.onn ? rd_o[c*8 +: 8] : p0[c*8 +: 8];
            if (step.first)
            begin
                s_next[c]  = SUM_W'(rsq_reg * pn[c]);
                a_next[c]  = RUN_W'(r1 * pn[c]);
                b_next[c]  = RUN_W'(r1 * pn[c]);
                pq_next[c] = pn[c];
            end
            else
            begin
                b_next[c]  = b_reg[c] - RUN_W'(pq_reg[c]) + RUN_W'(pn[c]);
                s_next[c]  = s_reg[c] - SUM_W'(a_reg[c]) + SUM_W'(b_next[c]);
                a_next[c]  = a_reg[c] + RUN_W'(qx[c]) - RUN_W'(qo[c]);
                pq_next[c] = qx[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s_reg[c] <= '0;
                a_reg[c] <= '0;
                b_reg[c] <= '0;
            end
            e2_reg <= 1'b0;
            e3_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s_reg[c] <= s_next[c];
                    a_reg[c] <= a_next[c];
                    b_reg[c] <= b_next[c];
                end
            end
            e2_reg <= s1_valid && step.xnn;
            e3_reg <= e2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pq_reg[c] <= pq_next[c];
            end
        end
        last2_reg  <= step.last;
        alpha2_reg <= step.fwd ? step.newval[31:24] : rd_x[31:24];
        last3_reg  <= last2_reg;
        alpha3_reg <= alpha2_reg;
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= PROD_W'(s_reg[c] * mult);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sh[c] = prod_reg[c] >> shift;
        end
    end

    assign push       = e3_reg;
    assign push_last  = last3_reg;
    assign push_pixel = {alpha3_reg, sh[2][7:0], sh[1][7:0], sh[0][7:0]};

endmodule

`default_nettype wire

[rtl/sbl_fifo.sv]
// ----------------------------------------------------------------------------
// sbl_fifo
// result queue between the scale stage and the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbl_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [31:0] push_pixel,
    input  wire logic        push_last,
    input  wire logic        pop,
    output logic             out_valid,
    output logic [31:0]      out_pixel,
    output logic             out_last
);
    import sbl_pkg::*;

    logic [32:0]        buf_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg;
    logic [FIFO_AW-1:0] rp_reg;
    logic [FIFO_AW:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_q[wp_reg] <= {push_last, push_pixel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_pixel = buf_q[rp_reg][31:0];
    assign out_last  = buf_q[rp_reg][32];

endmodule

`default_nettype wire

[rtl/stack_blur_line_filter.sv]
// ----------------------------------------------------------------------------
// stack_blur_line_filter
// one-dimensional stack blur over a line of argb pixels
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  pixel    in         pixel_valid/stall    pixel_in, last_in_line
//  result   out        result_valid/stall   pixel_out, last_out
//  cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
//  one pixel per cycle while not stalled; a window's last pixel passes ring
//  read, sum update, multiply and result queue before its result shows.
//  the last pixel of a line is followed by r_eff flush steps, with the
//  pixel channel stalled. stall also rises when eight results are pending.
//  reset clears control state; the window ring is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_blur_line_filter #(
    parameter int MAX_RADIUS = sbl_pkg::MAX_RADIUS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  wire logic [31:0] pixel_in,
    input  wire logic        last_in_line,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      pixel_out,
    output logic             last_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import sbl_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(2 * MAX_RADIUS + 2) + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [4:0]           radius_reg;
    logic [9:0]           mult_reg;
    logic [4:0]           shift_reg;
    logic [4:0]           r_eff;
    logic                 line_active_reg;
    logic                 flush_reg;
    logic [4:0]           fcnt_reg;
    logic [31:0]          lastpix_reg;
    logic [31:0]          p0_reg;
    logic signed [XW-1:0] xc_reg;
    logic signed [XW-1:0] oc_reg;
    logic [AW-1:0]        px_reg;
    logic [AW-1:0]        po_reg;
    logic [AW-1:0]        wp_reg;
    logic [FIFO_AW:0]     occ_reg;
    logic [FIFO_AW:0]     occ_next;
    logic                 s1_valid_reg;
    step_t                step_reg;
    step_t                step_next;

    logic                 credit;
    logic                 in_acc;
    logic                 step_go;
    logic                 first;
    logic                 pop;
    logic signed [XW-1:0] xcur;
    logic signed [XW-1:0] ocur;
    logic [AW-1:0]        pxcur;
    logic [AW-1:0]        pocur;
    logic [AW-1:0]        wpcur;
    logic                 xnn;
    logic                 onn;
    logic [31:0]          rd_x;
    logic [31:0]          rd_o;
    logic                 push;
    logic [31:0]          push_pixel;
    logic                 push_last;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign r_eff = (32'(radius_reg) > 32'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius_reg;

    assign credit      = (occ_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign pixel_stall = flush_reg || !credit;
    assign in_acc      = pixel_valid && !pixel_stall;
    assign step_go     = in_acc || (flush_reg && credit);
    assign first       = in_acc && !line_active_reg;
    assign cfg_ready   = 1'b1;
    assign pop         = result_valid && !result_stall;

    always_comb
    begin
        xcur  = first ? -$signed(XW'(r_eff)) : xc_reg;
        ocur  = first ? -$signed(XW'({r_eff, 1'b1})) : oc_reg;
        pxcur = first ? '0 : px_reg;
        pocur = first ? '0 : po_reg;
        wpcur = first ? '0 : wp_reg;
        xnn   = (xcur >= 0);
        onn   = (ocur >= 0);
        step_next.first  = first;
        step_next.xnn    = xnn;
        step_next.onn    = onn;
        step_next.fwd    = in_acc && (r_eff == 5'd0);
        step_next.last   = in_acc ? (last_in_line && (r_eff == 5'd0)) : (fcnt_reg == 5'd1);
        step_next.newval = in_acc ? pixel_in : lastpix_reg;
        occ_next = occ_reg + (FIFO_AW+1)'(step_go && xnn) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= RADIUS_RST;
            mult_reg        <= MULT_RST;
            shift_reg       <= SHIFT_RST;
            line_active_reg <= 1'b0;
            flush_reg       <= 1'b0;
            fcnt_reg        <= '0;
            xc_reg          <= '0;
            oc_reg          <= '0;
            px_reg          <= '0;
            po_reg          <= '0;
            wp_reg          <= '0;
            occ_reg         <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= step_go;
            if (step_go)
            begin
                xc_reg <= xnn ? xcur : xcur + 1'b1;
                oc_reg <= onn ? ocur : ocur + 1'b1;
                px_reg <= xnn ? slot_inc(pxcur) : pxcur;
                po_reg <= onn ? slot_inc(pocur) : pocur;
            end
            if (in_acc)
            begin
                wp_reg <= slot_inc(wpcur);
                if (last_in_line)
                begin
                    line_active_reg <= 1'b0;
                    flush_reg       <= (r_eff != 5'd0);
                    fcnt_reg        <= r_eff;
                end
                else
                begin
                    line_active_reg <= 1'b1;
                end
            end
            else if (step_go)
            begin
                fcnt_reg <= fcnt_reg - 5'd1;
                if (fcnt_reg == 5'd1)
                begin
                    flush_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RADIUS:
                    begin
                        radius_reg      <= cfg_data[4:0];
                        line_active_reg <= 1'b0;
                    end
                    REG_MULT:  mult_reg  <= cfg_data[9:0];
                    REG_SHIFT: shift_reg <= cfg_data[4:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            step_reg <= step_next;
        end
        if (in_acc && last_in_line)
        begin
            lastpix_reg <= pixel_in;
        end
        if (first)
        begin
            p0_reg <= pixel_in;
        end
    end

    sbl_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (in_acc),
        .waddr   (wpcur),
        .wdata   (pixel_in),
        .raddr_a (pxcur),
        .raddr_b (pocur),
        .rdata_a (rd_x),
        .rdata_b (rd_o)
    );

    sbl_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .step       (step_reg),
        .rd_x       (rd_x),
        .rd_o       (rd_o),
        .p0         (p0_reg),
        .r_eff      (r_eff),
        .mult       (mult_reg),
        .shift      (shift_reg),
        .push       (push),
        .push_pixel (push_pixel),
        .push_last  (push_last)
    );

    sbl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_pixel (push_pixel),
        .push_last  (push_last),
        .pop        (pop),
        .out_valid  (result_valid),
        .out_pixel  (pixel_out),
        .out_last   (last_out)
    );

endmodule

`default_nettype wire

[rtl/sbl_checker.sv]
// ----------------------------------------------------------------------------
// sbl_checker
// port-level checks of the stack blur line filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pixel_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [31:0] pixel_out,
    input wire logic        last_out
);

    // held result keeps its value
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(pixel_out) && $stable(last_out))
        else $error("result payload changed while stalled");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // reset empties the queue and the flush sequencer
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result shown during reset");

    a_reset_ready: assert property (@(posedge clk) !rst_n |-> !pixel_stall)
        else $error("pixel channel stalled during reset");

endmodule

bind stack_blur_line_filter sbl_checker u_sbl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_out    (pixel_out),
    .last_out     (last_out)
);

`default_nettype wire
